/* hdl/peak_detector_prominence_macros.svh */
// ----------------------------------------------------------------------------
// peak detector assertion macros
// shared concurrent assertion forms, clocked on clk and quiet during rst
// ----------------------------------------------------------------------------
`ifndef PEAK_DETECTOR_PROMINENCE_MACROS_SVH
`define PEAK_DETECTOR_PROMINENCE_MACROS_SVH

// plain property checked at every edge outside reset
`define PDP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define PDP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/pdp_pkg.sv */
// ----------------------------------------------------------------------------
// pdp_pkg
// shared constants, register indexes and types of the peak detector
// ----------------------------------------------------------------------------
package pdp_pkg;

  localparam int STORE_DEPTH   = 1024;
  localparam int SAMPLE_BITS   = 16;
  localparam int ADDR_BITS     = $clog2(STORE_DEPTH);
  localparam int CNT_BITS      = $clog2(STORE_DEPTH + 1);
  localparam int POS_BITS      = 10;
  localparam int MODE_BITS     = 2;
  localparam int THR_BITS      = 16;
  localparam int PROM_BITS     = 16;
  localparam int LIMIT_BITS    = 7;
  localparam int PEAK_LIMIT    = 64;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam int IN_DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((POS_BITS + SAMPLE_BITS + 7) / 8) * 8;
  localparam int DIFF_BITS     = SAMPLE_BITS + 1;
  localparam int CMP_BITS      = (DIFF_BITS > PROM_BITS) ? DIFF_BITS + 1 : PROM_BITS + 1;

  // detection modes, any other code runs as plain local maxima
  localparam logic [MODE_BITS-1:0] MODE_PLAIN      = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_THRESHOLD  = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_PROMINENCE = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_DETECT_MODE    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PEAK_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_PROMINENCE = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_PEAKS      = 2'd3;

  typedef struct packed {
    logic [MODE_BITS-1:0]       mode;
    logic signed [THR_BITS-1:0] threshold;
    logic [PROM_BITS-1:0]       min_prom;
    logic [LIMIT_BITS-1:0]      max_peaks;
  } cfg_t;

  // one queue entry: a candidate peak or the end-of-record mark
  typedef struct packed {
    logic                          is_end;
    logic [ADDR_BITS-1:0]          idx;
    logic signed [SAMPLE_BITS-1:0] value;
  } qent_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic room2;
  } qstat_t;

endpackage

/* hdl/pdp_store.sv */
// ----------------------------------------------------------------------------
// pdp_store
// sample memory, one write port and two registered read ports
// ----------------------------------------------------------------------------
module pdp_store import pdp_pkg::*; (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [ADDR_BITS-1:0]          wr_addr,
  input  logic signed [SAMPLE_BITS-1:0] wr_data,
  input  logic [ADDR_BITS-1:0]          rd_addr_a,
  output logic signed [SAMPLE_BITS-1:0] rd_data_a,
  input  logic [ADDR_BITS-1:0]          rd_addr_b,
  output logic signed [SAMPLE_BITS-1:0] rd_data_b
);

  logic signed [SAMPLE_BITS-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

/* hdl/pdp_queue.sv */
// ----------------------------------------------------------------------------
// pdp_queue
// short fifo of candidate peaks between the scan front and the back end
// ----------------------------------------------------------------------------
`include "peak_detector_prominence_macros.svh"

module pdp_queue import pdp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  qent_t  push_entry,
  input  logic   pop,
  output qent_t  head,
  output qstat_t stat
);

  qent_t                entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wp;
  logic [QPTR_BITS-1:0] rp;
  logic [QPTR_BITS:0]   count;

  assign head       = entries[rp];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign stat.room2 = (count <= (QPTR_BITS+1)'(QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + QPTR_BITS'(1);
      end
      if (pop) begin
        rp <= rp + QPTR_BITS'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + (QPTR_BITS+1)'(1);
        2'b01:   count <= count - (QPTR_BITS+1)'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wp] <= push_entry;
    end
  end

  `PDP_ASSERT(a_no_overflow, !(push && stat.full), "pdp_queue: push into full queue")
  `PDP_ASSERT(a_no_underflow, !(pop && stat.empty), "pdp_queue: pop from empty queue")
  `PDP_ASSERT_NEXT(a_push_fills, push && !pop, !stat.empty, "pdp_queue: push lost")

endmodule

/* hdl/pdp_front.sv */
// ----------------------------------------------------------------------------
// pdp_front
// loads samples into the store and scans the record for candidate peaks
// ----------------------------------------------------------------------------
module pdp_front import pdp_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  cfg_t                          cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_last,
  output logic                          wr_en,
  output logic [ADDR_BITS-1:0]          wr_addr,
  output logic signed [SAMPLE_BITS-1:0] wr_data,
  output logic [ADDR_BITS-1:0]          rd_addr,
  input  logic signed [SAMPLE_BITS-1:0] rd_data,
  output logic                          q_push,
  output qent_t                         q_entry,
  input  qstat_t                        q_stat,
  output logic [CNT_BITS-1:0]           rec_count,
  input  logic                          rec_done
);

  typedef enum logic [1:0] {ST_LOAD, ST_SCAN, ST_MARK, ST_HOLD} state_t;

  state_t                        state;
  logic [CNT_BITS-1:0]           cnt;
  logic [ADDR_BITS-1:0]          ra;
  logic                          more;
  logic                          dv;
  logic [ADDR_BITS-1:0]          da;
  logic signed [SAMPLE_BITS-1:0] w0;
  logic signed [SAMPLE_BITS-1:0] w1;

  logic                accept;
  logic                store_ok;
  logic [CNT_BITS-1:0] n_new;
  logic                issue;
  logic                ra_last;
  logic                da_last;
  logic                is_max;
  logic                thr_ok;
  logic                cand;

  always_comb begin
    in_ready = (state == ST_LOAD);
    accept   = in_valid && in_ready;
    store_ok = (cnt < CNT_BITS'(STORE_DEPTH));
    n_new    = store_ok ? cnt + CNT_BITS'(1) : cnt;
    wr_en    = accept && store_ok;
    wr_addr  = cnt[ADDR_BITS-1:0];
    wr_data  = in_sample;
    // issue only while two queue slots are free, one of them for the read in flight
    issue    = (state == ST_SCAN) && more && q_stat.room2;
    rd_addr  = ra;
    ra_last  = (CNT_BITS'(ra) == rec_count - CNT_BITS'(1));
    da_last  = (CNT_BITS'(da) == rec_count - CNT_BITS'(1));
    // w1 sits between w0 and the sample just read
    is_max   = (da > ADDR_BITS'(1)) && (w1 > w0) && (w1 > rd_data);
    thr_ok   = (cfg.mode != MODE_THRESHOLD) || (w1 >= cfg.threshold);
    cand     = (state == ST_SCAN) && dv && is_max && thr_ok;
    q_push   = cand || ((state == ST_MARK) && !q_stat.full);
    q_entry.is_end = (state == ST_MARK);
    q_entry.idx    = da - ADDR_BITS'(1);
    q_entry.value  = w1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      cnt   <= '0;
      more  <= 1'b0;
      dv    <= 1'b0;
    end else begin
      dv <= issue;
      if (issue) begin
        da <= ra;
        ra <= ra + ADDR_BITS'(1);
        if (ra_last) begin
          more <= 1'b0;
        end
      end
      if ((state == ST_SCAN) && dv) begin
        w0 <= w1;
        w1 <= rd_data;
      end
      unique case (state)
        ST_LOAD: begin
          if (accept) begin
            if (in_last) begin
              cnt       <= '0;
              rec_count <= n_new;
              ra        <= '0;
              if (n_new < CNT_BITS'(3)) begin
                state <= ST_MARK;
              end else begin
                more  <= 1'b1;
                state <= ST_SCAN;
              end
            end else begin
              cnt <= n_new;
            end
          end
        end
        ST_SCAN: begin
          if (dv && da_last) begin
            state <= ST_MARK;
          end
        end
        ST_MARK: begin
          if (!q_stat.full) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (rec_done) begin
            state <= ST_LOAD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

endmodule

/* hdl/pdp_back.sv */
// ----------------------------------------------------------------------------
// pdp_back
// qualifies candidate peaks by prominence and delivers the results
// ----------------------------------------------------------------------------
`include "peak_detector_prominence_macros.svh"

module pdp_back import pdp_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  cfg_t                          cfg,
  input  qent_t                         q_head,
  input  qstat_t                        q_stat,
  output logic                          q_pop,
  input  logic [CNT_BITS-1:0]           rec_count,
  output logic [ADDR_BITS-1:0]          rd_addr,
  input  logic signed [SAMPLE_BITS-1:0] rd_data,
  output logic                          rec_done,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [POS_BITS-1:0]           out_pos,
  output logic signed [SAMPLE_BITS-1:0] out_level,
  output logic                          out_found,
  output logic                          out_final
);

  typedef enum logic [1:0] {B_IDLE, B_LEFT, B_RIGHT, B_EVAL} state_t;

  state_t                        state;
  logic [LIMIT_BITS-1:0]         cnt;
  logic                          pend_v;
  logic [ADDR_BITS-1:0]          pend_pos;
  logic signed [SAMPLE_BITS-1:0] pend_val;
  logic [ADDR_BITS-1:0]          cur_idx;
  logic signed [SAMPLE_BITS-1:0] cur_val;
  logic [ADDR_BITS-1:0]          ptr;
  logic                          more;
  logic                          dv;
  logic signed [SAMPLE_BITS-1:0] minv;
  logic signed [SAMPLE_BITS-1:0] lmin;
  logic signed [SAMPLE_BITS-1:0] rmin;

  logic [LIMIT_BITS-1:0]         lim;
  logic                          out_free;
  logic                          have;
  logic                          room;
  logic                          end_go;
  logic                          drop;
  logic                          start_prom;
  logic                          take_direct;
  logic                          take_eval;
  logic                          take;
  logic [ADDR_BITS-1:0]          take_pos;
  logic signed [SAMPLE_BITS-1:0] take_val;
  logic                          load_out;
  logic                          walking;
  logic                          issue;
  logic                          hi;
  logic                          side_end;
  logic signed [SAMPLE_BITS-1:0] minv_upd;
  logic                          last_r;
  logic [DIFF_BITS-1:0]          lp;
  logic [DIFF_BITS-1:0]          rp;
  logic [DIFF_BITS-1:0]          prom;
  logic                          qual;

  always_comb begin
    if (cfg.max_peaks == '0) begin
      lim = LIMIT_BITS'(1);
    end else if (cfg.max_peaks > LIMIT_BITS'(PEAK_LIMIT)) begin
      lim = LIMIT_BITS'(PEAK_LIMIT);
    end else begin
      lim = cfg.max_peaks;
    end
  end

  always_comb begin
    out_free    = !out_valid || out_ready;
    have        = (state == B_IDLE) && !q_stat.empty;
    // a new peak pushes the held one out, so the output must have room
    room        = !pend_v || out_free;
    end_go      = have && q_head.is_end && out_free;
    drop        = have && !q_head.is_end && (cnt >= lim);
    start_prom  = have && !q_head.is_end && (cnt < lim) && (cfg.mode == MODE_PROMINENCE);
    take_direct = have && !q_head.is_end && (cnt < lim) && (cfg.mode != MODE_PROMINENCE)
                  && room;
    take_eval   = (state == B_EVAL) && qual && room;
    take        = take_direct || take_eval;
    take_pos    = take_direct ? q_head.idx : cur_idx;
    take_val    = take_direct ? q_head.value : cur_val;
    q_pop       = end_go || drop || start_prom || take_direct;
    load_out    = end_go || (take && pend_v);
    rec_done    = end_go;

    walking  = (state == B_LEFT) || (state == B_RIGHT);
    issue    = walking && more;
    rd_addr  = ptr;
    hi       = dv && (rd_data > cur_val);
    minv_upd = (dv && (rd_data < minv)) ? rd_data : minv;
    side_end = hi || !more;
    last_r   = (CNT_BITS'(ptr) == rec_count - CNT_BITS'(1));

    lp   = {cur_val[SAMPLE_BITS-1], cur_val} - {lmin[SAMPLE_BITS-1], lmin};
    rp   = {cur_val[SAMPLE_BITS-1], cur_val} - {rmin[SAMPLE_BITS-1], rmin};
    prom = (lp < rp) ? lp : rp;
    qual = (CMP_BITS'(prom) >= CMP_BITS'(cfg.min_prom));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      cnt       <= '0;
      pend_v    <= 1'b0;
      more      <= 1'b0;
      dv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      dv <= issue && !hi;
      if (walking) begin
        minv <= minv_upd;
      end

      unique case (state)
        B_IDLE: begin
          if (start_prom) begin
            cur_idx <= q_head.idx;
            cur_val <= q_head.value;
            ptr     <= q_head.idx - ADDR_BITS'(1);
            more    <= 1'b1;
            minv    <= q_head.value;
            state   <= B_LEFT;
          end
        end
        B_LEFT: begin
          if (side_end) begin
            lmin  <= minv_upd;
            minv  <= cur_val;
            ptr   <= cur_idx + ADDR_BITS'(1);
            more  <= 1'b1;
            state <= B_RIGHT;
          end else if (issue) begin
            ptr  <= ptr - ADDR_BITS'(1);
            more <= (ptr != '0);
          end
        end
        B_RIGHT: begin
          if (side_end) begin
            rmin  <= minv_upd;
            more  <= 1'b0;
            state <= B_EVAL;
          end else if (issue) begin
            ptr  <= ptr + ADDR_BITS'(1);
            more <= !last_r;
          end
        end
        B_EVAL: begin
          if (!qual || take_eval) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase

      if (take) begin
        pend_v   <= 1'b1;
        pend_pos <= take_pos;
        pend_val <= take_val;
        cnt      <= cnt + LIMIT_BITS'(1);
      end else if (end_go) begin
        pend_v <= 1'b0;
        cnt    <= '0;
      end

      if (load_out) begin
        out_valid <= 1'b1;
        out_pos   <= pend_v ? POS_BITS'(pend_pos) : '0;
        out_level <= pend_v ? pend_val : '0;
        out_found <= pend_v;
        out_final <= end_go;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `PDP_ASSERT(a_cnt_bound, cnt <= LIMIT_BITS'(PEAK_LIMIT), "pdp_back: peak count past limit")
  `PDP_ASSERT(a_pend_counted, !pend_v || (cnt != '0), "pdp_back: held peak not counted")
  `PDP_ASSERT_NEXT(a_done_final, rec_done, out_valid && out_final, "pdp_back: record end lost")

endmodule

/* hdl/peak_detector_prominence.sv */
// ----------------------------------------------------------------------------
// peak_detector_prominence
// local maximum peak detector with threshold or prominence qualification
// ----------------------------------------------------------------------------
// Samples stream in one per cycle and are written into a 1024-entry store;
// the request flagged tlast ends the record and starts detection, and the
// input stays stalled (s_tready low) until the record's last result sits in
// the output register. Detection walks the store once on read port A for
// strict local maxima at indices 1 to count-2, feeding candidates through a
// four-entry queue to the back end. In plain and threshold mode the back end
// takes each candidate straight from the queue head; in prominence mode it
// walks outward on read port B from each candidate until the first higher
// sample or the record edge, one sample per cycle each side, so on a long
// flat base each peak's walk can span much of the record. Up to max_peaks
// results (1..64) come out in index order, the last one with tlast set; a
// record shorter than three samples or with no peak gives one result with
// tuser (found) low. Samples past the store depth are dropped, though their
// tlast still ends the record. Configuration writes are meant for idle time.
// ----------------------------------------------------------------------------
module peak_detector_prominence import pdp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  // configuration write port
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  // sample requests
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [IN_DATA_BITS-1:0]  s_tdata,   // [15:0] sample (signed)
  input  logic                     s_tlast,   // record_end
  // peak results
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_DATA_BITS-1:0] m_tdata,   // [9:0] peak_position, [25:10] peak_level
  output logic                     m_tuser,   // found
  output logic                     m_tlast    // final_res
);

  cfg_t cfg;

  // register file, to be written by the user only while the block is idle; the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode      <= MODE_PLAIN;
      cfg.threshold <= '0;
      cfg.min_prom  <= '0;
      cfg.max_peaks <= LIMIT_BITS'(PEAK_LIMIT);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DETECT_MODE:    cfg.mode      <= cfg_data[MODE_BITS-1:0];
        REG_PEAK_THRESHOLD: cfg.threshold <= cfg_data[THR_BITS-1:0];
        REG_MIN_PROMINENCE: cfg.min_prom  <= cfg_data[PROM_BITS-1:0];
        REG_MAX_PEAKS:      cfg.max_peaks <= cfg_data[LIMIT_BITS-1:0];
        default:            cfg.mode      <= cfg.mode;
      endcase
    end
  end

  // store ports
  logic                          wr_en;
  logic [ADDR_BITS-1:0]          wr_addr;
  logic signed [SAMPLE_BITS-1:0] wr_data;
  logic [ADDR_BITS-1:0]          rd_addr_a;
  logic signed [SAMPLE_BITS-1:0] rd_data_a;
  logic [ADDR_BITS-1:0]          rd_addr_b;
  logic signed [SAMPLE_BITS-1:0] rd_data_b;

  // candidate queue
  logic   q_push;
  qent_t  q_entry;
  logic   q_pop;
  qent_t  q_head;
  qstat_t q_stat;

  logic [CNT_BITS-1:0] rec_count;
  logic                rec_done;

  // result fields from the back end
  logic [POS_BITS-1:0]           out_pos;
  logic signed [SAMPLE_BITS-1:0] out_level;

  assign m_tdata = OUT_DATA_BITS'({out_level, out_pos});

  pdp_store u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_data_a (rd_data_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_b (rd_data_b)
  );

  // front: load the record, then find local maxima
  pdp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_sample (s_tdata[SAMPLE_BITS-1:0]),
    .in_last   (s_tlast),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr_a),
    .rd_data   (rd_data_a),
    .q_push    (q_push),
    .q_entry   (q_entry),
    .q_stat    (q_stat),
    .rec_count (rec_count),
    .rec_done  (rec_done)
  );

  pdp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .stat       (q_stat)
  );

  // back: prominence walk, peak limit and result delivery
  pdp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_head    (q_head),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .rec_count (rec_count),
    .rd_addr   (rd_addr_b),
    .rd_data   (rd_data_b),
    .rec_done  (rec_done),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_pos   (out_pos),
    .out_level (out_level),
    .out_found (m_tuser),
    .out_final (m_tlast)
  );

endmodule

/* dv/peak_detector_prominence_test.sv */
// ----------------------------------------------------------------------------
// peak_detector_prominence_test
// self-checking bench: sample records go in, every peak result is predicted
// by a local copy of the detector and compared field by field as it leaves
// ----------------------------------------------------------------------------
module peak_detector_prominence_test;
  import pdp_pkg::*;

  // the one mode code the package leaves unnamed, must run as plain maxima
  localparam logic [MODE_BITS-1:0] MODE_SPARE = 2'd3;

  localparam int RAND_ITEMS  = 120;     // random sample requests, roughly
  localparam int SETTLE      = 8;       // idle cycles before a register write
  localparam int END_WAIT    = 40;      // quiet cycles after the last result
  localparam int LONG_HOLD   = 600;     // receiver hold-off for back pressure
  localparam int MAX_REPORTS = 10;      // mismatches printed in full
  localparam int TIMEOUT     = 5000000; // time units, far above a clean run

  // how a directed row is checked
  typedef enum logic [1:0] {
    CHK_MODEL,  // against the predictor
    CHK_NONE,   // typed: one "no peak" result
    CHK_PEAK    // typed: exactly one peak
  } chk_e;

  // shapes of random records
  typedef enum logic [2:0] {
    SHAPE_NOISE,
    SHAPE_WALK,
    SHAPE_HILLS,
    SHAPE_FLAT,
    SHAPE_ZIGZAG,
    SHAPE_EXTREME
  } shape_e;

  typedef struct packed {
    logic [POS_BITS-1:0]           pos;
    logic signed [SAMPLE_BITS-1:0] level;
    logic                          found;
    logic                          fin;
  } peak_res_t;

  typedef struct {
    bit                   wr_cfg;  // write the four registers before the record
    logic [MODE_BITS-1:0] mode;
    int                   thr;
    int                   prom;
    int                   maxp;
    int                   first;   // first entry in dir_smp
    int                   len;
    chk_e                 chk;
    int                   pos;
    int                   level;
  } dir_row_t;

  // dut ports
  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [IN_DATA_BITS-1:0]  s_tdata = '0;   // [15:0] sample (signed)
  logic                     s_tlast = 1'b0; // record_end
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_tdata;        // [9:0] peak_position, [25:10] peak_level
  logic                     m_tuser;        // found
  logic                     m_tlast;        // final_res

  peak_detector_prominence dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop in case the dut hangs or drops a result
  initial begin
    #(TIMEOUT);
    $display("RESULT: ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // predictor state: its own copy of the registers and of the current record
  // --------------------------------------------------------------------------
  logic [MODE_BITS-1:0]          set_mode      = MODE_PLAIN;
  logic signed [THR_BITS-1:0]    set_threshold = '0;
  logic [PROM_BITS-1:0]          set_min_prom  = '0;
  logic [LIMIT_BITS-1:0]         set_max_peaks = LIMIT_BITS'(PEAK_LIMIT);
  logic signed [SAMPLE_BITS-1:0] rec_samples [STORE_DEPTH];
  int                            rec_count = 0;

  peak_res_t peak_expect_q [$];   // results still owed by the dut
  int        miss_count = 0;

  // typed expectation that replaces the predictor for one directed record
  bit        typed_on = 1'b0;
  peak_res_t typed_res;

  // sender and receiver control
  int   burst_left = 0;
  bit   no_gaps = 1'b0;
  logic long_hold_req = 1'b0;

  // random record state
  int walk_val;
  int walk_dir;
  int walk_scale;

  // directed stimulus: samples of all rows back to back
  int dir_smp [31] = '{
    5,
    -32768, 32767, -32768,
    3, 9,
    7, 7, 7,
    -32768, 32767, -32768,
    -32768, -32767, -32768,
    -32768, 32767, -32768,
    -32767, 32767, -32768,
    0, 1, 0, 1, 0,
    2, 9, 4, 6, 1
  };

  dir_row_t dir_tab [10] = '{
    // reset settings, single sample: too short
    '{1'b0, MODE_PLAIN,      0,      0,     64, 0,  1, CHK_NONE, 0, 0},
    // reset settings, full-scale peak
    '{1'b0, MODE_PLAIN,      0,      0,     64, 1,  3, CHK_PEAK, 1, 32767},
    // two samples: too short
    '{1'b1, MODE_PLAIN,      0,      0,     64, 4,  2, CHK_NONE, 0, 0},
    // flat record has no strict maximum
    '{1'b1, MODE_PLAIN,      0,      0,     64, 6,  3, CHK_NONE, 0, 0},
    // peak exactly at the top threshold is accepted
    '{1'b1, MODE_THRESHOLD,  32767,  0,     64, 9,  3, CHK_PEAK, 1, 32767},
    // lowest threshold, peak at the bottom of the range
    '{1'b1, MODE_THRESHOLD,  -32768, 0,     64, 12, 3, CHK_PEAK, 1, -32767},
    // full 17-bit prominence reaches the top minimum
    '{1'b1, MODE_PROMINENCE, 0,      65535, 64, 15, 3, CHK_PEAK, 1, 32767},
    // one short of it on the left side
    '{1'b1, MODE_PROMINENCE, 0,      65535, 64, 18, 3, CHK_NONE, 0, 0},
    // spare mode runs plain, a zero limit acts as one peak
    '{1'b1, MODE_SPARE,      0,      0,     0,  21, 5, CHK_PEAK, 1, 1},
    // limit above the cap, zero prominence
    '{1'b1, MODE_PROMINENCE, 0,      0,     127, 26, 5, CHK_MODEL, 0, 0}
  };

  // strict local maximum at index i, qualified by the current mode
  function automatic bit is_peak(int i, int n);
    int p;
    int s;
    int j;
    int lmin;
    int rmin;
    int prom;
    int thr;
    int need;
    p = rec_samples[i];
    if (!(p > rec_samples[i-1] && p > rec_samples[i+1])) return 1'b0;
    case (set_mode)
      MODE_THRESHOLD: begin
        thr = set_threshold;
        return p >= thr;
      end
      MODE_PROMINENCE: begin
        // each side walks out until the first higher sample, which still counts
        lmin = p;
        rmin = p;
        for (j = i; j > 0; j--) begin
          s = rec_samples[j-1];
          if (s < lmin) lmin = s;
          if (s > p) break;
        end
        for (j = i + 1; j < n; j++) begin
          s = rec_samples[j];
          if (s < rmin) rmin = s;
          if (s > p) break;
        end
        // kept in int, so the 17-bit drop never wraps
        prom = (p - lmin < p - rmin) ? p - lmin : p - rmin;
        need = set_min_prom;
        return prom >= need;
      end
      default: return 1'b1;
    endcase
  endfunction

  // one accepted sample request; the record end posts the owed results
  function automatic void take_sample(logic signed [SAMPLE_BITS-1:0] smp, logic last);
    int        n;
    int        limit;
    int        i;
    int        pk_idx [$];
    peak_res_t r;
    // samples past the store depth are dropped, their record end still counts
    if (rec_count < STORE_DEPTH) begin
      rec_samples[rec_count] = smp;
      rec_count++;
    end
    if (!last) return;
    n = rec_count;
    rec_count = 0;
    if (typed_on) begin
      peak_expect_q.push_back(typed_res);
      return;
    end
    limit = set_max_peaks;
    if (limit < 1) limit = 1;
    if (limit > PEAK_LIMIT) limit = PEAK_LIMIT;
    if (n >= 3) begin
      for (i = 1; i + 1 < n && pk_idx.size() < limit; i++) begin
        if (is_peak(i, n)) pk_idx.push_back(i);
      end
    end
    if (pk_idx.size() == 0) begin
      // short record or nothing qualified: a single "none" result
      r.pos   = '0;
      r.level = '0;
      r.found = 1'b0;
      r.fin   = 1'b1;
      peak_expect_q.push_back(r);
    end else begin
      for (i = 0; i < pk_idx.size(); i++) begin
        r.pos   = POS_BITS'(pk_idx[i]);
        r.level = rec_samples[pk_idx[i]];
        r.found = 1'b1;
        r.fin   = (i == pk_idx.size() - 1);
        peak_expect_q.push_back(r);
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // result checker: every accepted result pops the oldest expectation
  // --------------------------------------------------------------------------
  function automatic void log_miss(string what, peak_res_t want, peak_res_t got);
    miss_count++;
    if (miss_count <= MAX_REPORTS) begin
      $display("mismatch (%s) at %0t: expected pos %0d level %0d found %0b last %0b, got pos %0d level %0d found %0b last %0b",
               what, $time, want.pos, want.level, want.found, want.fin,
               got.pos, got.level, got.found, got.fin);
    end
  endfunction

  always @(posedge clk) begin
    peak_res_t got;
    peak_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.pos   = m_tdata[POS_BITS-1:0];
      got.level = m_tdata[POS_BITS +: SAMPLE_BITS];
      got.found = m_tuser;
      got.fin   = m_tlast;
      if (peak_expect_q.size() == 0) begin
        log_miss("unexpected", '0, got);
      end else begin
        want = peak_expect_q.pop_front();
        if (got.pos !== want.pos || got.level !== want.level ||
            got.found !== want.found || got.fin !== want.fin) begin
          log_miss("field", want, got);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: 16-step ready pattern, redrawn from four styles, plus one long
  // hold-off on request so results back up and the input stalls
  // --------------------------------------------------------------------------
  logic [15:0] ready_pat = 16'hffff;
  int          pat_pos = 0;
  int          pat_age = 0;
  int          hold_left = 0;
  bit          long_hold_done = 1'b0;

  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (long_hold_req && !long_hold_done) begin
      m_tready       <= 1'b0;
      hold_left      <= LONG_HOLD;
      long_hold_done <= 1'b1;
    end else begin
      m_tready <= ready_pat[pat_pos];
      pat_pos  <= (pat_pos + 1) % 16;
      if (pat_age == 63) begin
        pat_age <= 0;
        case ($urandom_range(0, 3))
          0: ready_pat <= 16'hffff;                               // no stalls
          1: ready_pat <= 16'($urandom());                        // coin flips
          2: ready_pat <= 16'($urandom() | $urandom());           // rare stalls
          default: ready_pat <= 16'($urandom() & $urandom()) | 16'h0001; // mostly stalled
        endcase
      end else begin
        pat_age <= pat_age + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // sender side
  // --------------------------------------------------------------------------
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    // mirror the write into the predictor, at the register's own width
    case (idx)
      REG_DETECT_MODE:    set_mode      = val[MODE_BITS-1:0];
      REG_PEAK_THRESHOLD: set_threshold = val[THR_BITS-1:0];
      REG_MIN_PROMINENCE: set_min_prom  = val[PROM_BITS-1:0];
      REG_MAX_PEAKS:      set_max_peaks = val[LIMIT_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(logic [MODE_BITS-1:0] mode, int thr, int prom, int maxp);
    write_reg(REG_DETECT_MODE, CFG_DATA_BITS'(mode));
    write_reg(REG_PEAK_THRESHOLD, CFG_DATA_BITS'(thr));
    write_reg(REG_MIN_PROMINENCE, CFG_DATA_BITS'(prom));
    write_reg(REG_MAX_PEAKS, CFG_DATA_BITS'(maxp));
  endtask

  // one sample request; bursts of random length with random gaps between
  task automatic send_sample(logic signed [SAMPLE_BITS-1:0] smp, logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= IN_DATA_BITS'(smp);
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    take_sample(smp, last);
  endtask

  // idle until every owed result is back, then a short margin
  task automatic wait_results_done();
    s_tvalid <= 1'b0;
    while (peak_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] next_sample(shape_e shape, int k);
    int v;
    int step;
    case (shape)
      SHAPE_WALK: begin
        // small steps with many repeats, so plateaus and ties show up
        step = $urandom_range(0, 4);
        walk_val += (step - 2) * walk_scale;
        v = walk_val;
      end
      SHAPE_HILLS: begin
        // walk with momentum: rising and falling slopes of random size
        if ($urandom_range(0, 3) == 0) walk_dir = -walk_dir;
        step = $urandom_range(0, 1500);
        walk_val += walk_dir * step;
        v = walk_val;
      end
      SHAPE_FLAT: begin
        if ($urandom_range(0, 5) == 0) begin
          step = $urandom_range(0, 2);
          walk_val += step - 1;
        end
        v = walk_val;
      end
      SHAPE_ZIGZAG: begin
        step = $urandom_range(0, 32767);
        v = (k % 2 == 1) ? 1000 + step % 31768 : -32768 + step % 33768;
      end
      SHAPE_EXTREME: begin
        case ($urandom_range(0, 4))
          0: v = -32768;
          1: v = 32767;
          2: v = -32767;
          3: v = 32766;
          default: v = 0;
        endcase
      end
      default: begin
        step = $urandom_range(0, 65535);
        v = step - 32768;
      end
    endcase
    if (v > 32767) begin
      v = 32767;
      walk_val = v;
    end
    if (v < -32768) begin
      v = -32768;
      walk_val = v;
    end
    return SAMPLE_BITS'(v);
  endfunction

  task automatic send_record(shape_e shape, int len);
    int k;
    walk_val = $urandom_range(0, 8000);
    walk_val -= 4000;
    walk_dir = 1;
    walk_scale = $urandom_range(1, 400);
    for (k = 0; k < len; k++) send_sample(next_sample(shape, k), k == len - 1);
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    int                   r;
    int                   k;
    int                   nrec;
    int                   len;
    int                   rand_items;
    int                   thr;
    int                   prom;
    int                   maxp;
    logic [MODE_BITS-1:0] mode;
    shape_e               shape;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed table, one record per row, idle between rows
    for (r = 0; r < 10; r++) begin
      if (dir_tab[r].wr_cfg) begin
        apply_setting(dir_tab[r].mode, dir_tab[r].thr, dir_tab[r].prom, dir_tab[r].maxp);
      end
      typed_on        = (dir_tab[r].chk != CHK_MODEL);
      typed_res.pos   = POS_BITS'(dir_tab[r].pos);
      typed_res.level = SAMPLE_BITS'(dir_tab[r].level);
      typed_res.found = (dir_tab[r].chk == CHK_PEAK);
      typed_res.fin   = 1'b1;
      for (k = 0; k < dir_tab[r].len; k++) begin
        send_sample(SAMPLE_BITS'(dir_smp[dir_tab[r].first + k]), k == dir_tab[r].len - 1);
      end
      wait_results_done();
    end
    typed_on = 1'b0;

    // more peaks than the cap, with the receiver held off so the block fills
    // up and the next record's requests stall at the input
    apply_setting(MODE_PLAIN, 0, 0, 127);
    long_hold_req <= 1'b1;
    send_record(SHAPE_ZIGZAG, 150);
    send_record(SHAPE_HILLS, 12);
    wait_results_done();

    // record longer than the store: the tail is dropped, its end still counts
    apply_setting(MODE_PROMINENCE, 0, 20000, PEAK_LIMIT);
    send_record(SHAPE_NOISE, STORE_DEPTH + 6);
    wait_results_done();

    // random phases: a fresh setting, then a few records of mixed shapes
    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      case ($urandom_range(0, 3))
        0: mode = MODE_PLAIN;
        1: mode = MODE_THRESHOLD;
        2: mode = MODE_PROMINENCE;
        default: mode = MODE_SPARE;
      endcase
      case ($urandom_range(0, 4))
        0: thr = -32768;
        1: thr = 32767;
        2: thr = 0;
        3: begin
          thr = $urandom_range(0, 65535);
          thr -= 32768;
        end
        default: begin
          thr = $urandom_range(0, 9000);
          thr -= 3000;
        end
      endcase
      case ($urandom_range(0, 4))
        0: prom = 0;
        1: prom = 65535;
        2: prom = $urandom_range(0, 300);
        3: prom = $urandom_range(0, 65535);
        default: prom = $urandom_range(0, 3000);
      endcase
      case ($urandom_range(0, 5))
        0: maxp = 0;
        1: maxp = 1;
        2: maxp = PEAK_LIMIT;
        3: maxp = 127;
        4: maxp = $urandom_range(1, 6);
        default: maxp = $urandom_range(1, PEAK_LIMIT);
      endcase
      apply_setting(mode, thr, prom, maxp);
      no_gaps = ($urandom_range(0, 3) == 0);
      nrec = $urandom_range(2, 4);
      repeat (nrec) begin
        // mostly shaped signals that carry real peaks, some noise and edge cases
        case ($urandom_range(0, 9))
          0, 1: shape = SHAPE_NOISE;
          2: shape = SHAPE_WALK;
          6: shape = SHAPE_FLAT;
          7: shape = SHAPE_ZIGZAG;
          8: shape = SHAPE_EXTREME;
          default: shape = SHAPE_HILLS;
        endcase
        case ($urandom_range(0, 9))
          0: len = $urandom_range(1, 2);
          9: len = $urandom_range(20, 40);
          default: len = $urandom_range(3, 14);
        endcase
        send_record(shape, len);
        rand_items += len;
      end
      wait_results_done();
    end

    // drain and let the block go quiet before the verdict
    s_tvalid <= 1'b0;
    while (peak_expect_q.size() != 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);
    if (miss_count == 0 && peak_expect_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/pdp_pkg.sv
hdl/pdp_store.sv
hdl/pdp_queue.sv
hdl/pdp_front.sv
hdl/pdp_back.sv
hdl/peak_detector_prominence.sv
dv/peak_detector_prominence_test.sv
